/* rtl/assert_macros.svh */
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DLRP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DLRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/dlrp_pkg.sv */
// Shared types, constants and the generator step function for the random pool.
`timescale 1ns / 1ps

package dlrp_pkg;

    localparam int GEN_W          = 32;
    localparam int LAT_W          = 15;
    localparam int RING_W         = 7;
    localparam int OFF_W          = 7;
    localparam int POOL_DEPTH_DEF = 128;

    localparam logic [GEN_W-1:0] RESET_GEN_A = 32'h5465_7687;
    localparam logic [GEN_W-1:0] RESET_GEN_B = 32'h7264_1663;

    typedef enum logic [1:0] {
        REQ_ADVANCE     = 2'd0,
        REQ_LOAD_SEEDS  = 2'd1,
        REQ_READ_POOL   = 2'd2,
        REQ_RESET_INDEX = 2'd3
    } req_type_t;

    // 31 right shifts with feedback bit0 ^ bit4 into bit 30, in closed form.
    // On the first shift the old bit 31 lands on bit 30 and is ORed with the
    // feedback, so the first feedback bit also sees bit 31. Bits below 27 see
    // only original taps; the top four also see feedback from the first four
    // shifts. Bit 31 always ends up clear.
    function automatic logic [GEN_W-1:0] lfsr_step31(input logic [GEN_W-1:0] v);
        logic [GEN_W-1:0] r;
        logic             fb0;
        r   = '0;
        fb0 = v[31] | (v[0] ^ v[4]);
        for (int i = 0; i < 27; i++) begin
            r[i] = v[i] ^ v[i+4];
        end
        for (int i = 27; i < 31; i++) begin
            r[i] = v[i] ^ v[i-27] ^ v[i-23];
        end
        r[0]  = fb0;
        r[27] = v[27] ^ fb0;
        return r;
    endfunction

endpackage

/* rtl/dlrp_if.sv */
// Request and response channel interfaces for the random pool.
`timescale 1ns / 1ps

interface dlrp_req_if import dlrp_pkg::*; ();
    logic               valid;
    logic               ready;
    req_type_t          req_type;
    logic [GEN_W-1:0]   seed_a;
    logic [GEN_W-1:0]   seed_b;
    logic [OFF_W-1:0]   pool_offset;

    modport source (output valid, output req_type, output seed_a, output seed_b,
                    output pool_offset, input ready);
    modport sink   (input valid, input req_type, input seed_a, input seed_b,
                    input pool_offset, output ready);
endinterface

interface dlrp_rsp_if import dlrp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LAT_W-1:0]   rand_a_low15;
    logic [LAT_W-1:0]   rand_b_low15;
    logic [RING_W-1:0]  pool_value;

    modport source (output valid, output rand_a_low15, output rand_b_low15,
                    output pool_value, input ready);
    modport sink   (input valid, input rand_a_low15, input rand_b_low15,
                    input pool_value, output ready);
endinterface

/* rtl/dual_lfsr_random_pool.sv */
// Two 31-bit shift-register generators with a ring of recent 7-bit values.
//
// Every request word on req gives exactly one response word on rsp, in order.
// Throughput is one word per clock when rsp is not stalled; a request that is
// taken passes through the middle stage and then the response register before
// its response is valid on rsp. The rate is set by the ring memory, which
// serves one write (advance) or one read (read pool) per cycle, with
// registered read data. The 31 generator shifts are flattened into one level
// of tap logic, so both generators step as an advance is taken. The ring has
// no clearing pass: writes always start at index zero and walk upward, so the
// entries ever written form a prefix, and a fill count marks it; entries past
// it read as zero. A response register and one middle stage let a new request
// in while an earlier response still waits on rsp.
`timescale 1ns / 1ps

module dual_lfsr_random_pool import dlrp_pkg::*; #(
    parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    dlrp_req_if.sink    req,
    dlrp_rsp_if.source  rsp
);

    localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CNT_W = $clog2(POOL_DEPTH + 1);
    localparam int OFF_N = 2 ** OFF_W;

    localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(POOL_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_DEPTH - 1);

    // generator and latch state
    logic [GEN_W-1:0]  gen_a_reg, gen_a_next;
    logic [GEN_W-1:0]  gen_b_reg, gen_b_next;
    logic [LAT_W-1:0]  lat_a_reg, lat_a_next;
    logic [LAT_W-1:0]  lat_b_reg, lat_b_next;
    logic [IDX_W-1:0]  wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;

    // ring memory
    logic [RING_W-1:0] ring_reg [POOL_DEPTH];
    logic [RING_W-1:0] rd_data_reg;

    // middle stage: latched values and whether the word carries ring data
    logic              s1_valid_reg, s1_valid_next;
    logic [LAT_W-1:0]  s1_a_reg;
    logic [LAT_W-1:0]  s1_b_reg;
    logic              s1_hit_reg;

    // response register
    logic              out_valid_reg, out_valid_next;
    logic [LAT_W-1:0]  out_a_reg;
    logic [LAT_W-1:0]  out_b_reg;
    logic [RING_W-1:0] out_pool_reg;

    logic              accept;
    logic              out_free;
    logic              s1_move;
    logic              wr_en;
    logic              rd_en;
    logic [IDX_W-1:0]  off_tbl [OFF_N];
    logic [IDX_W-1:0]  off_mod;
    logic [IDX_W:0]    addr_sum;
    logic [IDX_W-1:0]  rd_addr;
    logic              rd_hit;
    logic [GEN_W-1:0]  step_a;
    logic [GEN_W-1:0]  step_b;

    // handshake and flow
    assign out_free  = !out_valid_reg || rsp.ready;
    assign s1_move   = s1_valid_reg && out_free;
    assign req.ready = !s1_valid_reg || out_free;
    assign accept    = req.valid && req.ready;

    assign wr_en = accept && (req.req_type == REQ_ADVANCE);
    assign rd_en = accept && (req.req_type == REQ_READ_POOL);

    // offset modulo depth: constant table over all 7-bit offsets
    for (genvar g = 0; g < OFF_N; g++) begin : g_off_tbl
        assign off_tbl[g] = IDX_W'(g % POOL_DEPTH);
    end

    assign off_mod  = off_tbl[req.pool_offset];
    assign addr_sum = {1'b0, wr_idx_reg} + {1'b0, off_mod};

    always_comb
    begin
        if (addr_sum >= DEPTH_X)
        begin
            rd_addr = IDX_W'(addr_sum - DEPTH_X);
        end
        else
        begin
            rd_addr = addr_sum[IDX_W-1:0];
        end
    end

    // entries at or above the fill count were never written since reset
    assign rd_hit = CNT_W'(rd_addr) < fill_reg;

    assign step_a = lfsr_step31(gen_a_reg);
    assign step_b = lfsr_step31(gen_b_reg);

    always_comb
    begin
        gen_a_next  = gen_a_reg;
        gen_b_next  = gen_b_reg;
        lat_a_next  = lat_a_reg;
        lat_b_next  = lat_b_reg;
        wr_idx_next = wr_idx_reg;
        fill_next   = fill_reg;
        if (accept)
        begin
            unique case (req.req_type)
                REQ_ADVANCE:
                begin
                    gen_a_next  = step_a;
                    gen_b_next  = step_b;
                    lat_a_next  = step_a[LAT_W-1:0];
                    lat_b_next  = step_b[LAT_W-1:0];
                    wr_idx_next = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + 1'b1;
                    // first write past the written prefix grows it
                    if (CNT_W'(wr_idx_reg) == fill_reg)
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
                REQ_LOAD_SEEDS:
                begin
                    gen_a_next = req.seed_a;
                    gen_b_next = req.seed_b;
                    lat_a_next = req.seed_a[LAT_W-1:0];
                    lat_b_next = req.seed_b[LAT_W-1:0];
                end
                REQ_READ_POOL:
                begin
                end
                REQ_RESET_INDEX:
                begin
                    wr_idx_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign s1_valid_next  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_move ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_a_reg     <= RESET_GEN_A;
            gen_b_reg     <= RESET_GEN_B;
            lat_a_reg     <= '0;
            lat_b_reg     <= '0;
            wr_idx_reg    <= '0;
            fill_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            gen_a_reg     <= gen_a_next;
            gen_b_reg     <= gen_b_next;
            lat_a_reg     <= lat_a_next;
            lat_b_reg     <= lat_b_next;
            wr_idx_reg    <= wr_idx_next;
            fill_reg      <= fill_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ring: advance stores the previous latched A value, read pool fetches
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_reg[wr_idx_reg] <= lat_a_reg[RING_W-1:0];
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_reg[rd_addr];
        end
    end

    // payload pipeline, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_a_reg   <= lat_a_next;
            s1_b_reg   <= lat_b_next;
            s1_hit_reg <= rd_en && rd_hit;
        end
        if (s1_move)
        begin
            out_a_reg    <= s1_a_reg;
            out_b_reg    <= s1_b_reg;
            out_pool_reg <= s1_hit_reg ? rd_data_reg : '0;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.rand_a_low15 = out_a_reg;
    assign rsp.rand_b_low15 = out_b_reg;
    assign rsp.pool_value   = out_pool_reg;

endmodule

/* rtl/dlrp_checker.sv */
// Port-level checks for the random pool, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dlrp_checker import dlrp_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input req_type_t          req_type,
    input logic [GEN_W-1:0]   seed_a,
    input logic [GEN_W-1:0]   seed_b,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [LAT_W-1:0]   rand_a_low15,
    input logic [LAT_W-1:0]   rand_b_low15,
    input logic [RING_W-1:0]  pool_value
);

    // stalled response word holds
    `DLRP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rand_a_low15) && $stable(rand_b_low15) && $stable(pool_value), "rsp word changed under stall")

    // empty output side never blocks requests
    `DLRP_ASSERT_IMPL(a_ready_idle, !rsp_valid, req_ready, "req blocked with rsp empty")

    // a fresh response traces back to a taken request word
    `DLRP_ASSERT_IMPL(a_rsp_origin, $rose(rsp_valid), $past(req_valid && req_ready, 2), "rsp without request")

    // seed load shows the new seeds' low bits
    `DLRP_ASSERT_IMPL(a_seed_latch, $rose(rsp_valid) && $past(req_type == REQ_LOAD_SEEDS, 2), rand_a_low15 == $past(seed_a[LAT_W-1:0], 2) && rand_b_low15 == $past(seed_b[LAT_W-1:0], 2), "seed load not latched")

    // only pool reads carry ring data
    `DLRP_ASSERT_IMPL(a_pool_zero, $rose(rsp_valid) && $past(req_type != REQ_READ_POOL, 2), pool_value == '0, "pool value on non-read")

endmodule

bind dual_lfsr_random_pool dlrp_checker u_dlrp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_type     (req.req_type),
    .seed_a       (req.seed_a),
    .seed_b       (req.seed_b),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rand_a_low15 (rsp.rand_a_low15),
    .rand_b_low15 (rsp.rand_b_low15),
    .pool_value   (rsp.pool_value)
);
